// File: hdl/fcgi_df_pkg.sv
// Shared types, record codes and state layout for the FastCGI record deframer.
package fcgi_df_pkg;

    localparam logic [7:0] REC_END_REQUEST = 8'd3;
    localparam logic [7:0] REC_STDOUT      = 8'd6;
    localparam logic [7:0] REC_STDERR      = 8'd7;
    localparam int         HDR_LEN_BYTES   = 8;

    localparam int HDR_POS_W = $clog2(HDR_LEN_BYTES);

    // Header byte positions that carry fields we keep.
    localparam logic [HDR_POS_W-1:0] HDR_POS_TYPE   = HDR_POS_W'(1);
    localparam logic [HDR_POS_W-1:0] HDR_POS_LEN_HI = HDR_POS_W'(4);
    localparam logic [HDR_POS_W-1:0] HDR_POS_LEN_LO = HDR_POS_W'(5);
    localparam logic [HDR_POS_W-1:0] HDR_POS_PAD    = HDR_POS_W'(6);
    localparam logic [HDR_POS_W-1:0] HDR_POS_LAST   = HDR_POS_W'(HDR_LEN_BYTES - 1);

    localparam int BODY_CNT_W = 17;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_BODY    = 3'b010,
        PH_STOPPED = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        KIND_STDOUT = 2'd0,
        KIND_STDERR = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef struct packed {
        t_phase                 phase;
        logic [HDR_POS_W-1:0]   hdr_pos;
        logic [7:0]             rec_kind;
        logic [15:0]            content_len;
        logic [7:0]             pad_len;
        logic [BODY_CNT_W-1:0]  body_cnt;
    } t_state;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

// File: hdl/fcgi_df_step.sv
// Per-byte next-state and result logic of the FastCGI record deframer.
module fcgi_df_step (
    input  fcgi_df_pkg::t_state  i_state,
    input  logic [7:0]           i_byte,
    output fcgi_df_pkg::t_state  o_state,
    output fcgi_df_pkg::t_result o_result
);
    import fcgi_df_pkg::*;

    logic [BODY_CNT_W-1:0] w_total;
    logic [BODY_CNT_W-1:0] w_cnt_next;
    logic [BODY_CNT_W:0]   w_cnt_inc;
    logic                  w_is_stream;

    assign w_total     = BODY_CNT_W'(i_state.content_len) + BODY_CNT_W'(i_state.pad_len);
    assign w_cnt_inc   = {1'b0, i_state.body_cnt} + (BODY_CNT_W+1)'(1);
    assign w_cnt_next  = w_cnt_inc[BODY_CNT_W-1:0];
    assign w_is_stream = (i_state.rec_kind == REC_STDOUT) ||
                         (i_state.rec_kind == REC_STDERR);

    always_comb begin
        o_state  = i_state;
        o_result = '{valid: 1'b0, kind: KIND_STDOUT, data: 8'd0, last: 1'b0};
        case (i_state.phase)
            PH_HEADER: begin
                case (i_state.hdr_pos)
                    HDR_POS_TYPE:   o_state.rec_kind = i_byte;
                    HDR_POS_LEN_HI: o_state.content_len[15:8] = i_byte;
                    HDR_POS_LEN_LO: o_state.content_len[7:0] = i_byte;
                    HDR_POS_PAD:    o_state.pad_len = i_byte;
                    default: ;
                endcase
                if (i_state.hdr_pos != HDR_POS_LAST) begin
                    o_state.hdr_pos = i_state.hdr_pos + HDR_POS_W'(1);
                end else begin
                    // The type, length and padding were all taken earlier in the header.
                    o_state.hdr_pos  = '0;
                    o_state.body_cnt = '0;
                    if (i_state.rec_kind == REC_END_REQUEST) begin
                        o_state.phase  = PH_STOPPED;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_END;
                    end else if (w_total != '0) begin
                        o_state.phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                o_state.body_cnt = w_cnt_next;
                if (w_cnt_next >= w_total) begin
                    o_state.phase   = PH_HEADER;
                    o_state.hdr_pos = '0;
                end
                if ((i_state.body_cnt < BODY_CNT_W'(i_state.content_len)) && w_is_stream) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = (i_state.rec_kind == REC_STDOUT) ? KIND_STDOUT
                                                                       : KIND_STDERR;
                    o_result.data  = i_byte;
                    o_result.last  = (w_cnt_inc == (BODY_CNT_W+1)'(i_state.content_len));
                end
            end
            default: begin
                // Stopped: every byte is dropped until reset.
                o_state.phase = PH_STOPPED;
            end
        endcase
    end

endmodule

// File: hdl/fastcgi_record_deframer_core.sv
// Top level of the FastCGI record deframer: input register, step logic, result register.
//
//  Channel | Direction | tdata           | tuser    | tlast
//  s       | in        | [7:0] in_byte   | -        | -
//  m       | out       | [7:0] data_byte | [1:0] kind | last_of_record
//
// One byte is taken every cycle unless the output stalls; each byte passes through the input register and
// then its result, if any, sits in the output register until the sink takes it.
// The record state is updated as a byte moves from the input register onward.
// Reset is synchronous and active low and returns the parser to header collection.
// A stall on the output holds both registers; the input accepts while either is free.
module fastcgi_record_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] data_byte
    output logic [1:0] o_m_tuser,   // [1:0] kind
    output logic       o_m_tlast    // last_of_record
);
    import fcgi_df_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic       w_adv;
    logic       w_s_take;

    fcgi_df_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_s_take   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_HEADER, hdr_pos: '0, rec_kind: '0,
                             content_len: '0, pad_len: '0, body_cnt: '0};
        end else begin
            if (w_s_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && n_result.valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_in_byte <= i_s_tdata;
        end
        if (w_adv) begin
            r_out_kind <= n_result.kind;
            r_out_data <= n_result.data;
            r_out_last <= n_result.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END) |-> (r_state.phase == PH_STOPPED))
        else $error("end result held while parser is not stopped");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_STOPPED) |-> (!r_out_valid || r_out_kind == KIND_END))
        else $error("content transfer pending after end of request");

    a_body_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_BODY) |-> (r_state.hdr_pos == '0))
        else $error("header position not cleared in body phase");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled while a register is free");
`endif

endmodule

// File: tb/sv/fastcgi_record_deframer_core_tb.sv
// Self-checking testbench for the FastCGI record deframer core.
`timescale 1ns / 1ps

module fastcgi_record_deframer_core_tb;

    import fcgi_df_pkg::*;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_frag;

    typedef struct {
        logic [7:0] b;
        bit         pinned;
        bit         pin_has;
        t_frag      pin_res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata = 8'h00;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [1:0] o_m_tuser;
    logic       o_m_tlast;

    // Parser state kept by the testbench.
    t_phase         ph = PH_HEADER;
    logic [2:0]     hdr_idx = '0;
    logic [7:0]     rec_type = '0;
    logic [15:0]    clen = '0;
    logic [7:0]     plen = '0;
    logic [16:0]    body_taken = '0;

    t_frag  pending_frags[$];
    t_frag  head_frag;
    t_row   opening_rows[$];
    t_row   closing_rows[$];
    int     errors = 0;
    int     bytes_sent = 0;
    int     src_idle = 0;
    int     sink_idle = 0;
    bit     sink_hold = 1'b0;

    fastcgi_record_deframer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] in_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] data_byte
        .o_m_tuser  (o_m_tuser),   // [1:0] kind
        .o_m_tlast  (o_m_tlast)    // last_of_record
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [7:0] b, output t_frag r);
        logic [16:0] idx;
        logic [16:0] total;
        r = '0;
        if (ph == PH_HEADER) begin
            case (hdr_idx)
                HDR_POS_TYPE:   rec_type = b;
                HDR_POS_LEN_HI: clen[15:8] = b;
                HDR_POS_LEN_LO: clen[7:0] = b;
                HDR_POS_PAD:    plen = b;
                default: ;
            endcase
            if (hdr_idx != HDR_POS_LAST) begin
                hdr_idx = hdr_idx + 3'd1;
                return 1'b0;
            end
            hdr_idx = '0;
            body_taken = '0;
            if (rec_type == REC_END_REQUEST) begin
                ph = PH_STOPPED;
                r.kind = KIND_END;
                return 1'b1;
            end
            if ({1'b0, clen} + {9'd0, plen} != 17'd0)
                ph = PH_BODY;
            return 1'b0;
        end
        if (ph == PH_BODY) begin
            idx = body_taken;
            total = {1'b0, clen} + {9'd0, plen};
            body_taken = idx + 17'd1;
            if (body_taken >= total) begin
                ph = PH_HEADER;
                hdr_idx = '0;
            end
            if (idx < {1'b0, clen} && (rec_type == REC_STDOUT || rec_type == REC_STDERR)) begin
                r.kind = (rec_type == REC_STDOUT) ? KIND_STDOUT : KIND_STDERR;
                r.data = b;
                r.last = (idx + 17'd1 == {1'b0, clen});
                return 1'b1;
            end
            return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic t_row row_free(input logic [7:0] b);
        t_row r;
        r.b = b;
        r.pinned = 1'b0;
        r.pin_has = 1'b0;
        r.pin_res = '0;
        return r;
    endfunction

    function automatic t_row row_pin(input logic [7:0] b, input bit has, input t_kind k,
                                     input logic [7:0] d, input logic l);
        t_row r;
        r.b = b;
        r.pinned = 1'b1;
        r.pin_has = has;
        r.pin_res.kind = k;
        r.pin_res.data = d;
        r.pin_res.last = l;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_byte(input logic [7:0] b, input bit pinned = 1'b0,
                             input bit pin_has = 1'b0, input t_frag pin_res = '0);
        t_frag res;
        bit    got;
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
        got = parse_byte(b, res);
        if (pinned) begin
            if (pin_has) pending_frags.push_back(pin_res);
        end else if (got) begin
            pending_frags.push_back(res);
        end
        @(negedge i_clk);
    endtask

    task automatic walk_rows(input t_row rows[$]);
        foreach (rows[i])
            push_byte(rows[i].b, rows[i].pinned, rows[i].pin_has, rows[i].pin_res);
    endtask

    task automatic send_record(input logic [7:0] typ, input logic [15:0] len,
                               input logic [7:0] pad);
        int n;
        n = int'(len) + int'(pad);
        push_byte(8'($urandom_range(255)));
        push_byte(typ);
        push_byte(8'($urandom_range(255)));
        push_byte(8'($urandom_range(255)));
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        push_byte(pad);
        push_byte(8'($urandom_range(255)));
        repeat (n) push_byte(8'($urandom_range(255)));
    endtask

    task automatic random_record();
        int          pick;
        int          lsel;
        logic [7:0]  typ;
        logic [15:0] len;
        logic [7:0]  pad;
        pick = $urandom_range(99);
        lsel = $urandom_range(99);
        if (lsel < 85)
            len = 16'($urandom_range(12));
        else if (lsel < 97)
            len = 16'($urandom_range(64, 13));
        else
            len = 16'($urandom_range(270, 250));
        pad = ($urandom_range(99) < 97) ? 8'($urandom_range(7)) : 8'hFF;
        if (pick < 40) begin
            typ = REC_STDOUT;
        end else if (pick < 75) begin
            typ = REC_STDERR;
        end else if (pick < 88) begin
            typ = 8'($urandom_range(255));
        end else if (pick < 94) begin
            typ = 8'($urandom_range(255));
            len = '0;
            pad = '0;
        end else begin
            // Garbage framing: any type, short content, any padding.
            typ = 8'($urandom_range(255));
            len = 16'($urandom_range(31));
            pad = 8'($urandom_range(255));
        end
        // An end-request header would stop the parser for good, so it only comes last.
        if (typ == REC_END_REQUEST) typ = REC_STDERR;
        send_record(typ, len, pad);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending_frags.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output side: random back-pressure plus one long hold when requested.
    always begin
        @(negedge i_clk);
        if (sink_hold) begin
            i_m_tready = 1'b0;
            repeat (200) @(negedge i_clk);
            sink_hold = 1'b0;
        end
        i_m_tready = ($urandom_range(99) >= sink_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_frags.size() == 0) begin
                $error("unexpected result: kind %0d data %0h last %0b",
                       o_m_tuser, o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                head_frag = pending_frags.pop_front();
                if (o_m_tuser != head_frag.kind) begin
                    $error("kind: expected %0d, got %0d", head_frag.kind, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata != head_frag.data) begin
                    $error("data_byte: expected %0h, got %0h", head_frag.data, o_m_tdata);
                    errors++;
                end
                if (o_m_tlast != head_frag.last) begin
                    $error("last_of_record: expected %0b, got %0b", head_frag.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        int src_pct[3];
        int sink_pct[3];
        int target;
        src_pct = '{37, 85, 0};
        sink_pct = '{85, 37, 0};

        // Stdout record with extreme ignored header bytes, two content bytes and one pad byte.
        opening_rows.push_back(row_free(8'hFF));
        opening_rows.push_back(row_free(REC_STDOUT));
        opening_rows.push_back(row_free(8'hFF));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h02));
        opening_rows.push_back(row_free(8'h01));
        opening_rows.push_back(row_free(8'hFF));
        opening_rows.push_back(row_pin(8'h00, 1'b1, KIND_STDOUT, 8'h00, 1'b0));
        opening_rows.push_back(row_pin(8'hFF, 1'b1, KIND_STDOUT, 8'hFF, 1'b1));
        opening_rows.push_back(row_pin(8'hAA, 1'b0, KIND_STDOUT, 8'h00, 1'b0));
        // Empty stderr record: straight back to header collection.
        opening_rows.push_back(row_free(8'h01));
        opening_rows.push_back(row_free(REC_STDERR));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h01));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h00));
        // Stderr record with a single content byte and no padding.
        opening_rows.push_back(row_free(8'h01));
        opening_rows.push_back(row_free(REC_STDERR));
        opening_rows.push_back(row_free(8'h12));
        opening_rows.push_back(row_free(8'h34));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h01));
        opening_rows.push_back(row_free(8'h00));
        opening_rows.push_back(row_free(8'h55));
        opening_rows.push_back(row_pin(8'h80, 1'b1, KIND_STDERR, 8'h80, 1'b1));

        // End-request header with a nonzero length; the bytes after it are all dropped.
        closing_rows.push_back(row_free(8'h01));
        closing_rows.push_back(row_free(REC_END_REQUEST));
        closing_rows.push_back(row_free(8'h00));
        closing_rows.push_back(row_free(8'h01));
        closing_rows.push_back(row_free(8'h12));
        closing_rows.push_back(row_free(8'h34));
        closing_rows.push_back(row_free(8'h05));
        closing_rows.push_back(row_pin(8'h00, 1'b1, KIND_END, 8'h00, 1'b0));
        closing_rows.push_back(row_free(8'h01));
        closing_rows.push_back(row_free(REC_STDOUT));
        closing_rows.push_back(row_free(8'h00));
        closing_rows.push_back(row_free(8'h01));
        closing_rows.push_back(row_free(8'h00));
        closing_rows.push_back(row_free(8'h04));
        closing_rows.push_back(row_free(8'h00));
        closing_rows.push_back(row_free(8'h00));
        closing_rows.push_back(row_free(8'hC3));
        closing_rows.push_back(row_free(8'h3C));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < 3; p++) begin
            src_idle = src_pct[p];
            sink_idle = sink_pct[p];
            if (p == 0) begin
                walk_rows(opening_rows);
                // Long output stall while content keeps coming, so the input backs up.
                sink_hold = 1'b1;
                send_record(REC_STDOUT, 16'd40, 8'd3);
            end
            target = bytes_sent + 300;
            while (bytes_sent < target) random_record();
            // Content length with a nonzero high byte and the largest padding.
            if (p == 2) send_record(REC_STDOUT, 16'h0100, 8'hFF);
            drain();
        end

        walk_rows(closing_rows);
        drain();
        repeat (8) @(posedge i_clk);
        if (pending_frags.size() != 0) begin
            $error("%0d results never arrived", pending_frags.size());
            errors++;
        end
        if (errors == 0)
            $display("[fastcgi_record_deframer_core] OK");
        else
            $display("[fastcgi_record_deframer_core] ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[fastcgi_record_deframer_core] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hdl/fcgi_df_pkg.sv
hdl/fcgi_df_step.sv
hdl/fastcgi_record_deframer_core.sv
tb/sv/fastcgi_record_deframer_core_tb.sv
